/* sv/gim_pkg.sv */
package gim_pkg;

    // Item operation codes.
    typedef enum logic [0:0] {
        OP_TICK = 1'b0,
        OP_DOSE = 1'b1
    } op_t;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_FIRST_MEAL_DELAY  = 1'b0,
        CFG_GLUCOSE_THRESHOLD = 1'b1
    } cfg_index_t;

    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        op_t         operation;
        logic [15:0] dose_units;
        logic [5:0]  meal_grams;
        logic [7:0]  next_meal_gap;
    } in_item_t;

    typedef struct packed {
        logic [31:0] glucose_mmol;
        logic        meal_taken;
        logic [31:0] minutes_now;
    } out_item_t;

    // Result of the state update, before the unit conversion.
    typedef struct packed {
        logic [31:0] glucose_raw;
        logic        meal_taken;
        logic [31:0] minutes_now;
    } core_res_t;

    // Fields that ride alongside the conversion pipeline unchanged.
    typedef struct packed {
        logic        meal_taken;
        logic [31:0] minutes_now;
    } side_t;

    // Reset values of the configuration.
    localparam logic [7:0]  FIRST_MEAL_DELAY_RST  = 8'd180;
    localparam logic [15:0] GLUCOSE_THRESHOLD_RST = 16'd250;

    // Rate coefficients, unsigned Q0.24, rounded to nearest.
    localparam int         COEF_FRAC = 24;
    localparam logic [23:0] C_K12  = 24'd6710886;   // 0.4
    localparam logic [23:0] C_KIQ  = 24'd10066330;  // 0.6
    localparam logic [23:0] C_KID  = 24'd5033165;   // 0.3
    localparam logic [23:0] C_KABS = 24'd5872026;   // 0.35
    localparam logic [23:0] C_KD2Q = 24'd6710886;   // 0.4
    localparam logic [23:0] C_KEMP = 24'd16777;     // 0.001

    localparam int TICK_MINUTES = 5;
    localparam int DOSE_SCALE   = 50;
    localparam int MEAL_SHIFT   = 3;    // eight times the grams

    // Compartment sums are kept signed, wide enough for six terms.
    localparam int SUM_W = 36;
    typedef logic signed [SUM_W-1:0] sum_t;

    // Conversion to mmol/l: (Q1 * 1000 + 9009) / 18018.
    localparam int          NUM_W       = 42;
    localparam int          NUM_HALF    = 21;
    localparam int          Q_W         = 28;
    localparam int          RECIP_SHIFT = 42;
    localparam logic [9:0]  SCALE_MUL   = 10'd1000;
    localparam logic [13:0] SCALE_BIAS  = 14'd9009;
    localparam logic [14:0] DIVISOR     = 15'd18018;
    localparam logic [27:0] RECIP_M     = 28'((64'd1 << RECIP_SHIFT) / 64'd18018);

    // Coefficient times compartment, rounded half up back to the compartment format.
    function automatic logic [31:0] mulc(input logic [23:0] c, input logic [31:0] v);
        logic [55:0] p;
        p = {32'b0, c} * {24'b0, v} + (56'd1 << (COEF_FRAC - 1));
        return p[55:24];
    endfunction

    function automatic sum_t widen(input logic [31:0] v);
        return sum_t'({4'b0, v});
    endfunction

    function automatic logic [31:0] clamp(input sum_t x);
        logic [31:0] r;
        if (x[SUM_W-1]) begin
            r = '0;
        end else if (x[SUM_W-2:32] != '0) begin
            r = '1;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [47:0] b);
        logic [47:0] s;
        s = {16'b0, a} + b;
        return (s[47:32] != '0) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

/* sv/gim_skid.sv */
module gim_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gim_pkg::in_item_t s_data,
    output logic              d_valid,
    input  logic              d_ready,
    output gim_pkg::in_item_t d_data
);
    import gim_pkg::*;

    logic     main_valid_reg, main_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    in_item_t main_data_reg, main_data_next;
    in_item_t skid_data_reg, skid_data_next;
    logic     accept;
    logic     main_load;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    // The holding register may take a new beat when empty or when it is drained.
    assign main_load = !main_valid_reg || d_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (main_load) begin
            main_valid_next = skid_valid_reg || accept;
            main_data_next  = skid_valid_reg ? skid_data_reg : s_data;
            skid_valid_next = 1'b0;
        end else if (accept) begin
            skid_valid_next = 1'b1;
            skid_data_next  = s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign d_valid = main_valid_reg;
    assign d_data  = main_data_reg;

endmodule

/* sv/gim_core.sv */
module gim_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  gim_pkg::cfg_index_t   cfg_index,
    input  logic [15:0]           cfg_wdata,
    input  logic                  item_valid,
    input  gim_pkg::in_item_t     item,
    input  logic                  adv,
    output logic                  res_valid,
    output gim_pkg::core_res_t    res
);
    import gim_pkg::*;

    logic [31:0] gut_first_reg,       gut_first_next;
    logic [31:0] gut_second_reg,      gut_second_next;
    logic [31:0] plasma_glucose_reg,  plasma_glucose_next;
    logic [31:0] tissue_glucose_reg,  tissue_glucose_next;
    logic [31:0] insulin_depot_reg,   insulin_depot_next;
    logic [31:0] plasma_insulin_reg,  plasma_insulin_next;
    logic [31:0] insulin_action_reg,  insulin_action_next;
    logic [31:0] elapsed_minutes_reg, elapsed_minutes_next;
    logic [7:0]  minutes_to_meal_reg, minutes_to_meal_next;
    logic [15:0] threshold_reg,       threshold_next;
    logic        res_valid_reg,       res_valid_next;
    core_res_t   res_reg,             res_next;

    logic [31:0] k12q1, k12q2, kidi, kiqx, kabs, kd1, kd2, emp;
    logic [47:0] thr_wide;
    logic [47:0] meal_add;
    logic [47:0] dose_add;
    logic [31:0] gut_first_tick;
    logic        meal_due;

    // All coefficient products come from the old state and run side by side.
    always_comb begin
        thr_wide = {32'b0, threshold_reg} << FRAC_BITS;
        k12q1    = mulc(C_K12,  plasma_glucose_reg);
        k12q2    = mulc(C_K12,  tissue_glucose_reg);
        kidi     = mulc(C_KID,  plasma_insulin_reg);
        kiqx     = mulc(C_KIQ,  insulin_action_reg);
        kabs     = mulc(C_KABS, insulin_depot_reg);
        kd1      = mulc(C_KD2Q, gut_first_reg);
        kd2      = mulc(C_KD2Q, gut_second_reg);
        emp      = ({16'b0, plasma_glucose_reg} > thr_wide) ?
                   mulc(C_KEMP, plasma_glucose_reg) : '0;
        meal_add = {42'b0, item.meal_grams} << (FRAC_BITS + MEAL_SHIFT);
        dose_add = ({32'b0, item.dose_units} * 48'(DOSE_SCALE)) << (FRAC_BITS - 8);
        meal_due = minutes_to_meal_reg <= 8'(TICK_MINUTES);
        gut_first_tick = clamp(widen(gut_first_reg) - widen(kd1));
    end

    always_comb begin
        gut_first_next       = gut_first_reg;
        gut_second_next      = gut_second_reg;
        plasma_glucose_next  = plasma_glucose_reg;
        tissue_glucose_next  = tissue_glucose_reg;
        insulin_depot_next   = insulin_depot_reg;
        plasma_insulin_next  = plasma_insulin_reg;
        insulin_action_next  = insulin_action_reg;
        elapsed_minutes_next = elapsed_minutes_reg;
        minutes_to_meal_next = minutes_to_meal_reg;
        threshold_next       = threshold_reg;
        res_valid_next       = res_valid_reg;
        res_next             = res_reg;

        if (adv) begin
            res_valid_next = item_valid;
            if (item_valid) begin
                res_next.meal_taken = 1'b0;
                if (item.operation == OP_DOSE) begin
                    insulin_depot_next = sat_add(insulin_depot_reg, dose_add);
                end else begin
                    plasma_glucose_next = clamp(widen(plasma_glucose_reg) - widen(k12q1)
                                              + widen(k12q2) - widen(kiqx)
                                              + widen(kd2) - widen(emp));
                    tissue_glucose_next = clamp(widen(tissue_glucose_reg) + widen(k12q1)
                                              - widen(k12q2));
                    plasma_insulin_next = clamp(widen(plasma_insulin_reg) + widen(kabs)
                                              - widen(kidi));
                    insulin_action_next = clamp(widen(insulin_action_reg) + widen(kidi)
                                              - widen(kiqx));
                    insulin_depot_next  = clamp(widen(insulin_depot_reg) - widen(kabs));
                    gut_second_next     = clamp(widen(gut_second_reg) + widen(kd1)
                                              - widen(kd2));
                    elapsed_minutes_next = elapsed_minutes_reg + 32'(TICK_MINUTES);
                    if (meal_due) begin
                        gut_first_next       = sat_add(gut_first_tick, meal_add);
                        minutes_to_meal_next = item.next_meal_gap;
                        res_next.meal_taken  = 1'b1;
                    end else begin
                        gut_first_next       = gut_first_tick;
                        minutes_to_meal_next = minutes_to_meal_reg - 8'(TICK_MINUTES);
                    end
                end
                res_next.glucose_raw = plasma_glucose_next;
                res_next.minutes_now = elapsed_minutes_next;
            end
        end

        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FIRST_MEAL_DELAY:  minutes_to_meal_next = cfg_wdata[7:0];
                CFG_GLUCOSE_THRESHOLD: threshold_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gut_first_reg       <= '0;
            gut_second_reg      <= '0;
            plasma_glucose_reg  <= '0;
            tissue_glucose_reg  <= '0;
            insulin_depot_reg   <= '0;
            plasma_insulin_reg  <= '0;
            insulin_action_reg  <= '0;
            elapsed_minutes_reg <= '0;
            minutes_to_meal_reg <= FIRST_MEAL_DELAY_RST;
            threshold_reg       <= GLUCOSE_THRESHOLD_RST;
            res_valid_reg       <= 1'b0;
        end else begin
            gut_first_reg       <= gut_first_next;
            gut_second_reg      <= gut_second_next;
            plasma_glucose_reg  <= plasma_glucose_next;
            tissue_glucose_reg  <= tissue_glucose_next;
            insulin_depot_reg   <= insulin_depot_next;
            plasma_insulin_reg  <= plasma_insulin_next;
            insulin_action_reg  <= insulin_action_next;
            elapsed_minutes_reg <= elapsed_minutes_next;
            minutes_to_meal_reg <= minutes_to_meal_next;
            threshold_reg       <= threshold_next;
            res_valid_reg       <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* sv/gim_scale.sv */
module gim_scale (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                res_valid,
    input  gim_pkg::core_res_t  res,
    output logic                m_valid,
    output gim_pkg::out_item_t  m_data
);
    import gim_pkg::*;

    localparam int STAGES = 5;
    localparam int SIDE_N = STAGES - 1;
    localparam int PP_W   = NUM_HALF + Q_W;

    logic [STAGES-1:0] vld_reg, vld_next;
    side_t             side_reg [SIDE_N];

    logic [NUM_W-1:0]  num_a_reg, num_b_reg, num_c_reg, num_d_reg;
    logic [PP_W-1:0]   pph_reg, ppl_reg;
    logic [Q_W-1:0]    qe_c_reg, qe_d_reg;
    logic [NUM_W-1:0]  qd_d_reg;
    out_item_t         out_reg;

    logic [NUM_W-1:0]        num_a_next;
    logic [PP_W-1:0]         pph_next, ppl_next;
    logic [NUM_W+Q_W-1:0]    pp_sum;
    logic [Q_W-1:0]          qe_c_next;
    logic [NUM_W:0]          qd_full;
    logic [NUM_W-1:0]        rem;
    out_item_t               out_next;

    always_comb begin
        num_a_next = {10'b0, res.glucose_raw} * {32'b0, SCALE_MUL} + {28'b0, SCALE_BIAS};
        // The quotient estimate is num * M >> 42, with num split into halves.
        pph_next   = {28'b0, num_a_reg[NUM_W-1:NUM_HALF]} * {21'b0, RECIP_M};
        ppl_next   = {28'b0, num_a_reg[NUM_HALF-1:0]} * {21'b0, RECIP_M};
        pp_sum     = ({21'b0, pph_reg} << NUM_HALF) + {21'b0, ppl_reg};
        qe_c_next  = pp_sum[NUM_W+Q_W-1:RECIP_SHIFT];
        qd_full    = {15'b0, qe_c_reg} * {28'b0, DIVISOR};
        // The estimate is low by at most one; the remainder tells which.
        rem        = num_d_reg - qd_d_reg;
        out_next.glucose_mmol = {4'b0, qe_d_reg}
                              + ((rem >= {27'b0, DIVISOR}) ? 32'd1 : 32'd0);
        out_next.meal_taken   = side_reg[SIDE_N-1].meal_taken;
        out_next.minutes_now  = side_reg[SIDE_N-1].minutes_now;
        vld_next = adv ? {vld_reg[STAGES-2:0], res_valid} : vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            num_a_reg   <= num_a_next;
            side_reg[0] <= {res.meal_taken, res.minutes_now};
            pph_reg     <= pph_next;
            ppl_reg     <= ppl_next;
            num_b_reg   <= num_a_reg;
            qe_c_reg    <= qe_c_next;
            num_c_reg   <= num_b_reg;
            qd_d_reg    <= qd_full[NUM_W-1:0];
            qe_d_reg    <= qe_c_reg;
            num_d_reg   <= num_c_reg;
            out_reg     <= out_next;
            for (int i = 1; i < SIDE_N; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign m_valid = vld_reg[STAGES-1];
    assign m_data  = out_reg;

endmodule

/* sv/glucose_insulin_model_step.sv */
// Reduced glucose and insulin patient model, advanced one beat at a time. A tick beat
// (operation 0) moves all seven compartments on by five simulated minutes, runs the meal
// timer and may add a meal from the beat's grams and gap fields; a dose beat (operation 1)
// only adds fifty times the dose to the insulin depot. Every input beat yields exactly one
// result beat with plasma glucose in mmol/l (unsigned Q16.16), the meal flag and the
// simulated minutes since reset. The block takes one beat per clock cycle when the result
// side keeps up. The state update of a beat is registered as the beat leaves the input
// register, using eight coefficient multipliers in parallel, so the next beat can follow
// at once; the division by 18.018 is a reciprocal multiplication spread over five further
// stages. The configuration port writes first_meal_delay (index 0, which also restarts the
// meal timer) and glucose_threshold (index 1); writes should only be made while no beat is
// in flight.

module glucose_insulin_model_step #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  gim_pkg::in_item_t    s_data,

    output logic                 m_valid,
    input  logic                 m_ready,
    output gim_pkg::out_item_t   m_data,

    input  logic                 cfg_wr_en,
    input  gim_pkg::cfg_index_t  cfg_index,
    input  logic [15:0]          cfg_wdata
);
    import gim_pkg::*;

    logic      item_valid;
    in_item_t  item;
    logic      adv;
    logic      res_valid;
    core_res_t res;

    // The whole pipeline moves together whenever the output register is free or being
    // emptied; the skid stage keeps s_ready registered despite this.
    assign adv = !m_valid || m_ready;

    gim_skid u_skid (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .d_valid (item_valid),
        .d_ready (adv),
        .d_data  (item)
    );

    // Patient state and configuration; one beat updated per cycle while the pipeline advances.
    gim_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item       (item),
        .adv        (adv),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Conversion of the glucose compartment to mmol/l.
    gim_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .res_valid (res_valid),
        .res       (res),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule
